FILE: hdl/wavhp_pkg.sv
// Shared types, codes and helpers for the WAV header stream parser.
// No dependencies; used by every module under hdl.
`default_nettype none

package wavhp_pkg;

  // Magic words, first character in the low byte
  localparam logic [31:0] MagicRiff = 32'h4646_4952;  // "RIFF"
  localparam logic [31:0] MagicWave = 32'h4556_4157;  // "WAVE"
  localparam logic [31:0] MagicFmt  = 32'h2074_6D66;  // "fmt "
  localparam logic [31:0] MagicData = 32'h6174_6164;  // "data"

  // fmt chunk size thresholds for the optional extension
  localparam logic [31:0] FmtBaseSize = 32'd16;
  localparam logic [31:0] FmtCbSize   = 32'd18;

  // Last field position of the variable-length header sections
  localparam logic [4:0] FmtBodyLast = 5'd15;
  localparam logic [4:0] ExtLast     = 5'd21;

  // Magic word selectors
  localparam logic [1:0] SelRiff = 2'd0;
  localparam logic [1:0] SelWave = 2'd1;
  localparam logic [1:0] SelFmt  = 2'd2;
  localparam logic [1:0] SelData = 2'd3;

  typedef enum logic [3:0] {
    PH_RIFF,
    PH_RIFF_SIZE,
    PH_WAVE,
    PH_FMT,
    PH_FMT_SIZE,
    PH_FMT_BODY,
    PH_CBSIZE,
    PH_EXT,
    PH_DATA,
    PH_DATA_SIZE,
    PH_PAYLOAD,
    PH_PAD,
    PH_DONE,
    PH_ERROR
  } phase_e;

  typedef enum logic [2:0] {
    ST_HEADER  = 3'd0,
    ST_SAMPLE  = 3'd1,
    ST_PAD     = 3'd2,
    ST_ERROR   = 3'd3,
    ST_IGNORED = 3'd4
  } status_e;

  // Captured header fields
  typedef struct packed {
    logic [31:0] data_size;
    logic [31:0] channel_mask;
    logic [15:0] valid_bits;
    logic [15:0] bits_per_sample;
    logic [15:0] block_align;
    logic [31:0] byte_rate;
    logic [31:0] sample_rate;
    logic [15:0] channel_count;
    logic [15:0] format_tag;
  } caps_t;

  // One result item
  typedef struct packed {
    status_e     status;
    logic [7:0]  sample_byte;
    logic        last_sample;
    caps_t       caps;
  } result_t;

  // Input item
  typedef struct packed {
    logic        start_of_file;
    logic [7:0]  in_byte;
  } item_t;

  function automatic logic [7:0] magic_char(input logic [1:0] sel, input logic [1:0] pos);
    logic [31:0] w;
    case (sel)
      SelRiff: w = MagicRiff;
      SelWave: w = MagicWave;
      SelFmt:  w = MagicFmt;
      default: w = MagicData;
    endcase
    return w[{pos, 3'b000} +: 8];
  endfunction

  function automatic logic [31:0] put_lane32(input logic [31:0] w, input logic [1:0] lane,
                                             input logic [7:0] b);
    logic [31:0] r;
    r = w;
    r[{lane, 3'b000} +: 8] = b;
    return r;
  endfunction

  function automatic logic [15:0] put_lane16(input logic [15:0] w, input logic lane,
                                             input logic [7:0] b);
    logic [15:0] r;
    r = w;
    if (lane) begin
      r[15:8] = b;
    end else begin
      r[7:0] = b;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/wavhp_in_stage.sv
// Input register of the WAV header parser: holds one accepted byte transaction.
// Depends on wavhp_pkg.
`default_nettype none

module wavhp_in_stage (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            valid_i,
  output logic                 ready_o,
  input  wire wavhp_pkg::item_t item_i,
  output logic                 valid_o,
  input  wire logic            ready_i,
  output wavhp_pkg::item_t     item_o
);

  logic             valid_q;
  wavhp_pkg::item_t item_q;

  // Take a new transaction when empty or when the held one moves on
  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

`default_nettype wire

FILE: hdl/wavhp_parser.sv
// Parse state and single-step header logic of the WAV header parser.
// Depends on wavhp_pkg.
`default_nettype none

module wavhp_parser (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              step_i,
  input  wire wavhp_pkg::item_t  item_i,
  output wavhp_pkg::result_t     result_o
);

  wavhp_pkg::phase_e  phase_q, phase_d, ph;
  logic [4:0]         pos_q, pos_d, pos;
  logic               mism_q, mism_d, mism;
  logic [31:0]        asm_q, asm_d, asm_w, asm_new;
  logic [31:0]        fmt_q, fmt_d, fmt_w;
  logic [31:0]        rem_q, rem_d, rem_w;
  logic               pad_q, pad_d, pad_w;
  wavhp_pkg::caps_t   caps_q, caps_d, caps_w;

  logic [7:0]         b;
  logic [1:0]         magic_sel;
  wavhp_pkg::phase_e  magic_next;
  logic               bad;
  logic [4:0]         pos_off;
  wavhp_pkg::status_e status;
  logic [7:0]         sample;
  logic               last;

  assign b = item_i.in_byte;

  // State as seen by this byte: a start flag clears everything first
  always_comb begin
    if (item_i.start_of_file) begin
      ph    = wavhp_pkg::PH_RIFF;
      pos   = '0;
      mism  = 1'b0;
      asm_w = '0;
      fmt_w = '0;
      rem_w = '0;
      pad_w = 1'b0;
      caps_w = '0;
    end else begin
      ph    = phase_q;
      pos   = pos_q;
      mism  = mism_q;
      asm_w = asm_q;
      fmt_w = fmt_q;
      rem_w = rem_q;
      pad_w = pad_q;
      caps_w = caps_q;
    end
  end

  // Magic word and follow-on phase for the four magic phases
  always_comb begin
    case (ph)
      wavhp_pkg::PH_RIFF: begin
        magic_sel  = wavhp_pkg::SelRiff;
        magic_next = wavhp_pkg::PH_RIFF_SIZE;
      end
      wavhp_pkg::PH_WAVE: begin
        magic_sel  = wavhp_pkg::SelWave;
        magic_next = wavhp_pkg::PH_FMT;
      end
      wavhp_pkg::PH_FMT: begin
        magic_sel  = wavhp_pkg::SelFmt;
        magic_next = wavhp_pkg::PH_FMT_SIZE;
      end
      default: begin
        magic_sel  = wavhp_pkg::SelData;
        magic_next = wavhp_pkg::PH_DATA_SIZE;
      end
    endcase
  end

  assign bad     = mism || (b != wavhp_pkg::magic_char(magic_sel, pos[1:0]));
  assign asm_new = wavhp_pkg::put_lane32(asm_w, pos[1:0], b);
  assign pos_off = pos - 5'd2;

  // One parse step
  always_comb begin
    phase_d = ph;
    pos_d   = pos;
    mism_d  = mism;
    asm_d   = asm_w;
    fmt_d   = fmt_w;
    rem_d   = rem_w;
    pad_d   = pad_w;
    caps_d  = caps_w;
    status  = wavhp_pkg::ST_HEADER;
    sample  = '0;
    last    = 1'b0;
    case (ph)
      wavhp_pkg::PH_RIFF, wavhp_pkg::PH_WAVE, wavhp_pkg::PH_FMT, wavhp_pkg::PH_DATA: begin
        if (pos[1:0] == 2'd3) begin
          pos_d  = '0;
          mism_d = 1'b0;
          if (bad) begin
            phase_d = wavhp_pkg::PH_ERROR;
            status  = wavhp_pkg::ST_ERROR;
          end else begin
            phase_d = magic_next;
          end
        end else begin
          mism_d = bad;
          pos_d  = {3'b000, pos[1:0]} + 5'd1;
        end
      end
      wavhp_pkg::PH_RIFF_SIZE: begin
        if (pos >= 5'd3) begin
          pos_d   = '0;
          phase_d = wavhp_pkg::PH_WAVE;
        end else begin
          pos_d = pos + 5'd1;
        end
      end
      wavhp_pkg::PH_FMT_SIZE: begin
        if (pos >= 5'd3) begin
          fmt_d   = asm_new;
          asm_d   = '0;
          pos_d   = '0;
          phase_d = wavhp_pkg::PH_FMT_BODY;
        end else begin
          asm_d = asm_new;
          pos_d = pos + 5'd1;
        end
      end
      wavhp_pkg::PH_FMT_BODY: begin
        // tag, channels, sample rate, byte rate, align, bits
        if (pos < 5'd4) begin
          if (pos[1]) begin
            caps_d.channel_count = wavhp_pkg::put_lane16(caps_w.channel_count, pos[0], b);
          end else begin
            caps_d.format_tag = wavhp_pkg::put_lane16(caps_w.format_tag, pos[0], b);
          end
        end else if (pos < 5'd8) begin
          caps_d.sample_rate = wavhp_pkg::put_lane32(caps_w.sample_rate, pos[1:0], b);
        end else if (pos < 5'd12) begin
          caps_d.byte_rate = wavhp_pkg::put_lane32(caps_w.byte_rate, pos[1:0], b);
        end else if (pos[1]) begin
          caps_d.bits_per_sample = wavhp_pkg::put_lane16(caps_w.bits_per_sample, pos[0], b);
        end else begin
          caps_d.block_align = wavhp_pkg::put_lane16(caps_w.block_align, pos[0], b);
        end
        if (pos >= wavhp_pkg::FmtBodyLast) begin
          pos_d   = '0;
          phase_d = (fmt_w > wavhp_pkg::FmtBaseSize) ? wavhp_pkg::PH_CBSIZE
                                                     : wavhp_pkg::PH_DATA;
        end else begin
          pos_d = pos + 5'd1;
        end
      end
      wavhp_pkg::PH_CBSIZE: begin
        if (pos >= 5'd1) begin
          pos_d   = '0;
          phase_d = (fmt_w > wavhp_pkg::FmtCbSize) ? wavhp_pkg::PH_EXT
                                                   : wavhp_pkg::PH_DATA;
        end else begin
          pos_d = pos + 5'd1;
        end
      end
      wavhp_pkg::PH_EXT: begin
        // valid bits, channel mask, then SubFormat is skipped
        if (pos < 5'd2) begin
          caps_d.valid_bits = wavhp_pkg::put_lane16(caps_w.valid_bits, pos[0], b);
        end else if (pos < 5'd6) begin
          caps_d.channel_mask = wavhp_pkg::put_lane32(caps_w.channel_mask, pos_off[1:0], b);
        end
        if (pos >= wavhp_pkg::ExtLast) begin
          pos_d   = '0;
          phase_d = wavhp_pkg::PH_DATA;
        end else begin
          pos_d = pos + 5'd1;
        end
      end
      wavhp_pkg::PH_DATA_SIZE: begin
        caps_d.data_size = wavhp_pkg::put_lane32(caps_w.data_size, pos[1:0], b);
        if (pos >= 5'd3) begin
          rem_d   = asm_new;
          pad_d   = asm_new[0];
          asm_d   = '0;
          pos_d   = '0;
          phase_d = (asm_new == '0) ? wavhp_pkg::PH_DONE : wavhp_pkg::PH_PAYLOAD;
        end else begin
          asm_d = asm_new;
          pos_d = pos + 5'd1;
        end
      end
      wavhp_pkg::PH_PAYLOAD: begin
        status = wavhp_pkg::ST_SAMPLE;
        sample = b;
        rem_d  = rem_w - 32'd1;
        if (rem_w == 32'd1) begin
          last    = 1'b1;
          phase_d = pad_w ? wavhp_pkg::PH_PAD : wavhp_pkg::PH_DONE;
        end
      end
      wavhp_pkg::PH_PAD: begin
        status  = wavhp_pkg::ST_PAD;
        pad_d   = 1'b0;
        phase_d = wavhp_pkg::PH_DONE;
      end
      wavhp_pkg::PH_ERROR: begin
        status = wavhp_pkg::ST_ERROR;
      end
      default: begin
        status = wavhp_pkg::ST_IGNORED;
      end
    endcase
  end

  // Parse state registers, advanced once per transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= wavhp_pkg::PH_RIFF;
      pos_q   <= '0;
      mism_q  <= 1'b0;
      asm_q   <= '0;
      fmt_q   <= '0;
      rem_q   <= '0;
      pad_q   <= 1'b0;
      caps_q  <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      mism_q  <= mism_d;
      asm_q   <= asm_d;
      fmt_q   <= fmt_d;
      rem_q   <= rem_d;
      pad_q   <= pad_d;
      caps_q  <= caps_d;
    end
  end

  assign result_o.status      = status;
  assign result_o.sample_byte = sample;
  assign result_o.last_sample = last;
  assign result_o.caps        = caps_d;

  // Error state holds every byte until a start flag
  a_error_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && phase_q == wavhp_pkg::PH_ERROR && !item_i.start_of_file
    |-> status == wavhp_pkg::ST_ERROR)
    else $error("error state left without start");

  // Last mark only on a sample byte
  a_last_is_sample: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last |-> status == wavhp_pkg::ST_SAMPLE)
    else $error("last mark outside payload");

  // Final payload byte ends the payload
  a_payload_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && !item_i.start_of_file && phase_q == wavhp_pkg::PH_PAYLOAD && rem_q == 32'd1
    |=> phase_q == wavhp_pkg::PH_PAD || phase_q == wavhp_pkg::PH_DONE)
    else $error("payload did not end on final byte");

  // A start byte never leaves the parser past the riff magic prefix
  a_start_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && item_i.start_of_file
    |=> (phase_q == wavhp_pkg::PH_RIFF && pos_q == 5'd1) || phase_q == wavhp_pkg::PH_ERROR)
    else $error("start flag did not restart the parse");

endmodule

`default_nettype wire

FILE: hdl/wavhp_out_stage.sv
// Result register of the WAV header parser: holds one result transaction.
// Depends on wavhp_pkg.
`default_nettype none

module wavhp_out_stage (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               valid_i,
  output logic                    ready_o,
  input  wire wavhp_pkg::result_t result_i,
  output logic                    valid_o,
  input  wire logic               ready_i,
  output wavhp_pkg::result_t      result_o
);

  logic               valid_q;
  wavhp_pkg::result_t result_q;

  // Load when empty or when the held result is taken
  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      result_q <= result_i;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = result_q;

endmodule

`default_nettype wire

FILE: hdl/wav_header_stream_parser_top.sv
// WAV header stream parser, top level: input register, parser step, result register.
// Depends on wavhp_pkg, wavhp_in_stage, wavhp_parser, wavhp_out_stage.
//
// Feed a WAV file one byte per transaction, with tuser high on its first byte. Every
// byte yields exactly one result transaction. An accepted byte is held in the input
// register, and its result is registered in the result register. tuser carries
// the byte status (header, sample, pad, header error, ignored after end), tlast marks
// the final payload byte, and tdata carries the sample byte plus all header fields
// captured so far. The block sustains one byte per clock while the result side takes
// every result; that figure is set by the parser step, which updates the parse state
// once per byte, with a register in front of and behind it. Backpressure on the result
// side stalls input only once both registers are full.
`default_nettype none

module wav_header_stream_parser_top (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  input  wire logic [7:0]   s_axis_tdata_i,   // [7:0] in_byte
  input  wire logic         s_axis_tuser_i,   // [0] start_of_file
  output logic              m_axis_tvalid_o,
  input  wire logic         m_axis_tready_i,
  // [7:0] sample_byte, [23:8] format_tag, [39:24] channel_count, [71:40] sample_rate,
  // [103:72] byte_rate, [119:104] block_align, [135:120] bits_per_sample,
  // [151:136] valid_bits, [183:152] channel_mask, [215:184] data_size
  output logic [215:0]      m_axis_tdata_o,
  output logic [2:0]        m_axis_tuser_o,   // [2:0] byte_status
  output logic              m_axis_tlast_o    // last_sample
);

  wavhp_pkg::item_t   in_item, held_item;
  wavhp_pkg::result_t step_result, out_result;
  logic               held_valid;
  logic               out_ready;
  logic               step;

  assign in_item.start_of_file = s_axis_tuser_i;
  assign in_item.in_byte       = s_axis_tdata_i;

  wavhp_in_stage u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid_i),
    .ready_o (s_axis_tready_o),
    .item_i  (in_item),
    .valid_o (held_valid),
    .ready_i (out_ready),
    .item_o  (held_item)
  );

  // Parser advances when the held byte moves into the result register
  assign step = held_valid && out_ready;

  wavhp_parser u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .item_i   (held_item),
    .result_o (step_result)
  );

  wavhp_out_stage u_out_stage (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (held_valid),
    .ready_o  (out_ready),
    .result_i (step_result),
    .valid_o  (m_axis_tvalid_o),
    .ready_i  (m_axis_tready_i),
    .result_o (out_result)
  );

  // Pack result fields, highest first
  assign m_axis_tdata_o = {out_result.caps.data_size,
                           out_result.caps.channel_mask,
                           out_result.caps.valid_bits,
                           out_result.caps.bits_per_sample,
                           out_result.caps.block_align,
                           out_result.caps.byte_rate,
                           out_result.caps.sample_rate,
                           out_result.caps.channel_count,
                           out_result.caps.format_tag,
                           out_result.sample_byte};
  assign m_axis_tuser_o = out_result.status;
  assign m_axis_tlast_o = out_result.last_sample;

endmodule

`default_nettype wire

FILE: tb/wav_header_stream_parser_top_test.sv
// Testbench for wav_header_stream_parser_top: whole and broken WAV byte streams go in, and
// every result transaction is checked against an in-bench model of the header parse.
// Depends on wavhp_pkg and the parser RTL under hdl.
module wav_header_stream_parser_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import wavhp_pkg::*;

  localparam int RandomItems = 850;

  // Content of header fields and payload bytes
  localparam int FillRandom = 0;
  localparam int FillZero   = 1;
  localparam int FillOnes   = 2;

  // Receiver stall behavior
  localparam int RxAlways = 0;
  localparam int RxCoin   = 1;
  localparam int RxSparse = 2;
  localparam int RxBursty = 3;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_tvalid = 1'b0;
  logic [7:0]   s_tdata = '0;
  logic         s_tuser = 1'b0;
  logic         m_tready = 1'b0;
  logic         s_tready;
  logic         m_tvalid;
  logic [215:0] m_tdata;
  logic [2:0]   m_tuser;
  logic         m_tlast;

  wav_header_stream_parser_top u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser),
    .m_axis_tlast_o  (m_tlast)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Run limit
  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // Parser model state
  phase_e       wav_phase;
  logic [4:0]   field_pos;
  logic         magic_bad;
  logic [31:0]  size_word;
  logic [31:0]  fmt_size;
  logic [31:0]  bytes_left;
  logic         pad_due;
  // Captures as one byte array in caps_t order: fmt body bytes 0..15 land in lanes 0..15,
  // valid bits and channel mask in lanes 16..21, data size in lanes 22..25
  logic [207:0] cap_bytes;

  result_t      predicted_results[$];
  logic [7:0]   wav_bytes[$];
  int           data_magic_at;
  int           error_count = 0;
  int           sent_count = 0;
  int           burst_left = 0;

  task automatic clear_parser();
    wav_phase  = PH_RIFF;
    field_pos  = '0;
    magic_bad  = 1'b0;
    size_word  = '0;
    fmt_size   = '0;
    bytes_left = '0;
    pad_due    = 1'b0;
    cap_bytes  = '0;
  endtask

  // One magic byte; a mismatch anywhere in the word shows on its fourth byte
  task automatic check_magic(input logic [31:0] word, input logic [7:0] b, input phase_e nxt,
                             inout status_e st);
    logic [1:0] lane;
    logic       bad;
    lane = field_pos[1:0];
    bad = magic_bad || (b != word[8*lane +: 8]);
    if (lane == 2'd3) begin
      field_pos = '0;
      magic_bad = 1'b0;
      if (bad) begin
        wav_phase = PH_ERROR;
        st = ST_ERROR;
      end else begin
        wav_phase = nxt;
      end
    end else begin
      magic_bad = bad;
      field_pos = field_pos + 5'd1;
    end
  endtask

  task automatic next_field(input logic [4:0] pos, input logic [4:0] last, input phase_e nxt);
    if (pos >= last) begin
      field_pos = '0;
      wav_phase = nxt;
    end else begin
      field_pos = pos + 5'd1;
    end
  endtask

  // Expected result of one accepted byte
  task automatic parse_byte(input logic sof, input logic [7:0] b, output result_t r);
    logic [4:0] pos;
    status_e    st;
    phase_e     nxt;
    pos = field_pos;
    st = ST_HEADER;
    r.sample_byte = '0;
    r.last_sample = 1'b0;
    if (sof) clear_parser();
    case (wav_phase)
      PH_RIFF:      check_magic(MagicRiff, b, PH_RIFF_SIZE, st);
      PH_RIFF_SIZE: next_field(pos, 5'd3, PH_WAVE);
      PH_WAVE:      check_magic(MagicWave, b, PH_FMT, st);
      PH_FMT:       check_magic(MagicFmt, b, PH_FMT_SIZE, st);
      PH_FMT_SIZE: begin
        size_word[8*pos[1:0] +: 8] = b;
        if (pos >= 5'd3) begin
          fmt_size = size_word;
          size_word = '0;
        end
        next_field(pos, 5'd3, PH_FMT_BODY);
      end
      PH_FMT_BODY: begin
        cap_bytes[8*pos +: 8] = b;
        nxt = PH_DATA;
        if (fmt_size > FmtBaseSize) nxt = PH_CBSIZE;
        next_field(pos, FmtBodyLast, nxt);
      end
      PH_CBSIZE: begin
        nxt = PH_DATA;
        if (fmt_size > FmtCbSize) nxt = PH_EXT;
        next_field(pos, 5'd1, nxt);
      end
      PH_EXT: begin
        // SubFormat bytes past lane 21 are dropped
        if (pos < 5'd6) cap_bytes[8*(16+pos) +: 8] = b;
        next_field(pos, ExtLast, PH_DATA);
      end
      PH_DATA:      check_magic(MagicData, b, PH_DATA_SIZE, st);
      PH_DATA_SIZE: begin
        size_word[8*pos[1:0] +: 8] = b;
        cap_bytes[8*(22+pos[1:0]) +: 8] = b;
        nxt = PH_PAYLOAD;
        if (pos >= 5'd3) begin
          bytes_left = size_word;
          pad_due = size_word[0];
          size_word = '0;
          if (bytes_left == '0) nxt = PH_DONE;
        end
        next_field(pos, 5'd3, nxt);
      end
      PH_PAYLOAD: begin
        st = ST_SAMPLE;
        r.sample_byte = b;
        bytes_left = bytes_left - 32'd1;
        if (bytes_left == '0) begin
          r.last_sample = 1'b1;
          wav_phase = pad_due ? PH_PAD : PH_DONE;
        end
      end
      PH_PAD: begin
        st = ST_PAD;
        pad_due = 1'b0;
        wav_phase = PH_DONE;
      end
      PH_ERROR: st = ST_ERROR;
      default:  st = ST_IGNORED;
    endcase
    r.status = st;
    r.caps = cap_bytes;
  endtask

  // Sender: bursts of random length with random gaps between them
  task automatic send_byte(input logic sof, input logic [7:0] b);
    result_t r;
    int      gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 40);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tuser  <= sof;
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    burst_left--;
    sent_count++;
    parse_byte(sof, b, r);
    predicted_results.push_back(r);
  endtask

  function automatic logic [7:0] fill_byte(input int fill);
    case (fill)
      FillZero: return 8'h00;
      FillOnes: return 8'hFF;
      default:  return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic void push_word(input logic [31:0] w);
    for (int i = 0; i < 4; i++) wav_bytes.push_back(w[8*i +: 8]);
  endfunction

  // Assemble a file in wav_bytes; the pad byte follows only a complete odd payload
  function automatic void build_wav(input logic [31:0] fmt_sz, input logic [31:0] data_sz,
                                    input int payload_n, input int fill);
    int body_n;
    body_n = 16 + ((fmt_sz > FmtBaseSize) ? 2 : 0) + ((fmt_sz > FmtCbSize) ? 22 : 0);
    wav_bytes.delete();
    push_word(MagicRiff);
    push_word($urandom());
    push_word(MagicWave);
    push_word(MagicFmt);
    push_word(fmt_sz);
    repeat (body_n) wav_bytes.push_back(fill_byte(fill));
    data_magic_at = wav_bytes.size();
    push_word(MagicData);
    push_word(data_sz);
    repeat (payload_n) wav_bytes.push_back(fill_byte(fill));
    if (payload_n == int'(data_sz) && data_sz[0]) wav_bytes.push_back(fill_byte(fill));
  endfunction

  task automatic send_wav(input logic sof_first, input int trailing);
    for (int i = 0; i < wav_bytes.size(); i++) send_byte(sof_first && i == 0, wav_bytes[i]);
    repeat (trailing) send_byte(1'b0, 8'($urandom_range(0, 255)));
  endtask

  // Straight after reset the parser expects RIFF, so no start flag is needed
  task automatic test_first_file_no_start();
    build_wav(32'd16, 32'd3, 3, FillRandom);
    send_wav(1'b0, 2);
  endtask

  // Full extension with every fmt field at its maximum
  task automatic test_extensible_fmt();
    build_wav(32'd40, 32'd4, 4, FillOnes);
    send_wav(1'b1, 1);
  endtask

  // cbSize only, empty data chunk, then bytes past the end
  task automatic test_cbsize_empty_data();
    build_wav(32'd18, 32'd0, 0, FillZero);
    send_wav(1'b1, 2);
  endtask

  // A bad byte in each magic word, at different positions in the word
  task automatic test_magic_errors();
    build_wav(32'd16, 32'd2, 2, FillRandom);
    wav_bytes[0] = 8'h72;
    while (wav_bytes.size() > 6) void'(wav_bytes.pop_back());
    send_wav(1'b1, 0);
    build_wav(32'd16, 32'd2, 2, FillRandom);
    wav_bytes[11] = wav_bytes[11] ^ 8'h80;
    while (wav_bytes.size() > 14) void'(wav_bytes.pop_back());
    send_wav(1'b1, 0);
    build_wav(32'd16, 32'd2, 2, FillRandom);
    wav_bytes[13] = 8'h00;
    while (wav_bytes.size() > 18) void'(wav_bytes.pop_back());
    send_wav(1'b1, 0);
    build_wav(32'd17, 32'd2, 2, FillRandom);
    wav_bytes[data_magic_at + 2] = 8'hFF;
    send_wav(1'b1, 1);
  endtask

  // Huge data size cut short by a new start, then a file with cbSize and a pad byte
  task automatic test_restart_mid_payload();
    build_wav(32'd16, 32'hFFFF_FFFF, 5, FillRandom);
    send_wav(1'b1, 0);
    build_wav(32'd17, 32'd1, 1, FillRandom);
    send_wav(1'b1, 1);
  endtask

  // Mostly whole files with random content, plus corrupted, truncated and noise streams
  task automatic test_random_streams();
    int          goal;
    int          kind;
    int          pick;
    int          payload_n;
    int          fill;
    int          idx;
    logic [31:0] fmt_sz;
    logic [31:0] data_sz;
    goal = sent_count + RandomItems;
    while (sent_count < goal) begin
      kind = $urandom_range(0, 99);
      pick = $urandom_range(0, 6);
      case (pick)
        0:       fmt_sz = 32'd16;
        1:       fmt_sz = 32'd17;
        2:       fmt_sz = 32'd18;
        3:       fmt_sz = 32'd19;
        4:       fmt_sz = 32'd40;
        5:       fmt_sz = 32'($urandom_range(0, 15));
        default: fmt_sz = $urandom();
      endcase
      if ($urandom_range(0, 4) == 0) begin
        data_sz = $urandom();
      end else begin
        data_sz = 32'($urandom_range(0, 20));
      end
      payload_n = (data_sz <= 32'd24) ? int'(data_sz) : $urandom_range(0, 12);
      pick = $urandom_range(0, 19);
      fill = (pick == 0) ? FillZero : (pick == 1) ? FillOnes : FillRandom;
      build_wav(fmt_sz, data_sz, payload_n, fill);
      if (kind < 70) begin
        // well-formed, now and then cut short anywhere
        if ($urandom_range(0, 9) == 0) begin
          idx = $urandom_range(1, wav_bytes.size());
          while (wav_bytes.size() > idx) void'(wav_bytes.pop_back());
        end
        send_wav($urandom_range(0, 9) != 0, $urandom_range(0, 3));
      end else if (kind < 85) begin
        // one broken magic byte
        case ($urandom_range(0, 3))
          0:       idx = 0;
          1:       idx = 8;
          2:       idx = 12;
          default: idx = data_magic_at;
        endcase
        idx += $urandom_range(0, 3);
        wav_bytes[idx] = wav_bytes[idx] ^ 8'($urandom_range(1, 255));
        send_wav(1'b1, $urandom_range(0, 3));
      end else begin
        // noise with scattered start flags
        repeat ($urandom_range(1, 16)) begin
          send_byte($urandom_range(0, 7) == 0, 8'($urandom_range(0, 255)));
        end
      end
    end
  endtask

  // Receiver stall pattern; the mode changes whenever the hold counter runs out
  int rx_mode = RxAlways;
  int rx_hold = 0;

  always @(posedge clk_i) begin
    if (rx_hold == 0) begin
      rx_mode <= $urandom_range(RxAlways, RxBursty);
      rx_hold <= $urandom_range(16, 120);
    end else begin
      rx_hold <= rx_hold - 1;
    end
    case (rx_mode)
      RxAlways: m_tready <= 1'b1;
      RxCoin:   m_tready <= 1'($urandom_range(0, 1));
      RxSparse: m_tready <= ($urandom_range(0, 3) == 0);
      default:  m_tready <= rx_hold[2];
    endcase
  end

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, exp_v, act_v);
      error_count++;
    end
  endtask

  // Compare each result transaction with the oldest prediction
  always @(posedge clk_i) begin : check_results
    result_t exp_r;
    caps_t   act_caps;
    if (rst_ni && m_tvalid && m_tready) begin
      if (predicted_results.size() == 0) begin
        $error("result transaction with no prediction pending");
        error_count++;
      end else begin
        exp_r = predicted_results.pop_front();
        act_caps = m_tdata[215:8];
        check_field("byte_status", 32'(exp_r.status), 32'(m_tuser));
        check_field("sample_byte", 32'(exp_r.sample_byte), 32'(m_tdata[7:0]));
        check_field("last_sample", 32'(exp_r.last_sample), 32'(m_tlast));
        check_field("format_tag", 32'(exp_r.caps.format_tag), 32'(act_caps.format_tag));
        check_field("channel_count", 32'(exp_r.caps.channel_count),
                    32'(act_caps.channel_count));
        check_field("sample_rate", exp_r.caps.sample_rate, act_caps.sample_rate);
        check_field("byte_rate", exp_r.caps.byte_rate, act_caps.byte_rate);
        check_field("block_align", 32'(exp_r.caps.block_align), 32'(act_caps.block_align));
        check_field("bits_per_sample", 32'(exp_r.caps.bits_per_sample),
                    32'(act_caps.bits_per_sample));
        check_field("valid_bits", 32'(exp_r.caps.valid_bits), 32'(act_caps.valid_bits));
        check_field("channel_mask", exp_r.caps.channel_mask, act_caps.channel_mask);
        check_field("data_size", exp_r.caps.data_size, act_caps.data_size);
      end
    end
  end

  initial begin : run_tests
    int drain_cycles;
    clear_parser();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_first_file_no_start();
    test_extensible_fmt();
    test_cbsize_empty_data();
    test_magic_errors();
    test_restart_mid_payload();
    test_random_streams();
    s_tvalid <= 1'b0;
    // drain outstanding results, then allow for the two-register pipeline
    drain_cycles = 0;
    while (predicted_results.size() != 0 && drain_cycles < 5000) begin
      @(posedge clk_i);
      drain_cycles++;
    end
    repeat (10) @(posedge clk_i);
    if (predicted_results.size() != 0) begin
      $error("%0d predicted results never arrived", predicted_results.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
